// ===== src/mer_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, datapath operation codes and handshake structs of the ellipse rasterizer
package mer_pkg;

    // decision value width, four times the real decision value
    localparam int DEC_BITS   = 48;
    // width of the start offset fields
    localparam int START_BITS = 10;

    // input transaction kinds
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ_RX,
        OP_SQ_RY,
        OP_RX2RY,
        OP_INIT_D,
        OP_ADV,
        OP_UPD_M1,
        OP_UPD_M2,
        OP_UPD_A2,
        OP_CMP_M1,
        OP_CMP_M2,
        OP_SW_TX,
        OP_SW_RY2,
        OP_SW_TY,
        OP_SW_RX2,
        OP_SW_RR,
        OP_SW_FIN,
        OP_CHECK_END
    } mer_op_t;

    typedef struct packed {
        mer_op_t op;
        logic    emit_load;
    } mer_cmd_t;

    typedef struct packed {
        logic active;
        logic region_two;
        logic below;
    } mer_stat_t;

endpackage

// ===== src/mer_datapath.sv =====
`timescale 1ns / 1ps
// walk registers, decision value and the shared multiplier of the ellipse rasterizer
module mer_datapath #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mer_pkg::mer_op_t                    op,
    input  logic signed [COORD_BITS-1:0]        center_x,
    input  logic signed [COORD_BITS-1:0]        center_y,
    input  logic        [RADIUS_BITS-1:0]       radius_x,
    input  logic        [RADIUS_BITS-1:0]       radius_y,
    input  logic        [mer_pkg::START_BITS-1:0] start_x,
    input  logic        [mer_pkg::START_BITS-1:0] start_y,
    output mer_pkg::mer_stat_t                  stat,
    output logic signed [COORD_BITS-1:0]        hold_cx,
    output logic signed [COORD_BITS-1:0]        hold_cy,
    output logic signed [COORD_BITS-1:0]        point_x,
    output logic signed [COORD_BITS-1:0]        point_y
);
    import mer_pkg::*;

    localparam int SQ_BITS  = 2 * RADIUS_BITS;
    localparam int MUL_BITS = ((COORD_BITS > RADIUS_BITS) ? 2 * COORD_BITS : 2 * RADIUS_BITS) + 1;

    // control state
    logic act_reg, act_next;
    logic r2_reg, r2_next;

    // payload
    logic signed [COORD_BITS-1:0]  cx_reg, cx_next;
    logic signed [COORD_BITS-1:0]  cy_reg, cy_next;
    logic        [RADIUS_BITS-1:0] rxh_reg, rxh_next;
    logic        [RADIUS_BITS-1:0] ryh_reg, ryh_next;
    logic        [SQ_BITS-1:0]     rx2_reg, rx2_next;
    logic        [SQ_BITS-1:0]     ry2_reg, ry2_next;
    logic signed [COORD_BITS-1:0]  x_reg, x_next;
    logic signed [COORD_BITS-1:0]  y_reg, y_next;
    logic signed [COORD_BITS-1:0]  ox_reg, ox_next;
    logic signed [COORD_BITS-1:0]  oy_reg, oy_next;
    logic                          diag_reg, diag_next;
    logic signed [DEC_BITS-1:0]    d_reg, d_next;
    logic signed [DEC_BITS-1:0]    tmp_reg, tmp_next;
    logic signed [DEC_BITS-1:0]    prod_reg, prod_next;

    logic signed [COORD_BITS-1:0]  x_inc, y_dec;
    logic signed [COORD_BITS:0]    tx, ty;
    logic signed [COORD_BITS+1:0]  two_y_m1;
    logic signed [SQ_BITS:0]       rx2_s, ry2_s;
    logic signed [RADIUS_BITS:0]   rx_s, ry_s;
    logic signed [MUL_BITS-1:0]    mul_a, mul_b;
    logic signed [2*MUL_BITS-1:0]  mul_full;
    logic signed [DEC_BITS-1:0]    prod4, prod8, ry2_4, rx2_d;
    logic                          d_neg, d_pos, diag_now;

    assign x_inc    = x_reg + COORD_BITS'(1);
    assign y_dec    = y_reg - COORD_BITS'(1);
    // 2x+1 and y-1 of the current walk point, exact
    assign tx       = {x_reg, 1'b1};
    assign ty       = {y_reg[COORD_BITS-1], y_reg} - (COORD_BITS+1)'(1);
    assign two_y_m1 = {y_reg[COORD_BITS-1], y_reg, 1'b0} - (COORD_BITS+2)'(1);
    assign rx2_s    = {1'b0, rx2_reg};
    assign ry2_s    = {1'b0, ry2_reg};
    assign rx_s     = {1'b0, rxh_reg};
    assign ry_s     = {1'b0, ryh_reg};
    assign prod4    = {prod_reg[DEC_BITS-3:0], 2'b00};
    assign prod8    = {prod_reg[DEC_BITS-4:0], 3'b000};
    assign ry2_4    = DEC_BITS'({ry2_reg, 2'b00});
    assign rx2_d    = DEC_BITS'(rx2_reg);
    assign d_neg    = d_reg[DEC_BITS-1];
    assign d_pos    = !d_neg && (d_reg != '0);
    // both coordinates move on this step
    assign diag_now = r2_reg ? !d_pos : !d_neg;

    // operand selection of the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            OP_SQ_RX:
            begin
                mul_a = MUL_BITS'(rx_s);
                mul_b = MUL_BITS'(rx_s);
            end
            OP_SQ_RY:
            begin
                mul_a = MUL_BITS'(ry_s);
                mul_b = MUL_BITS'(ry_s);
            end
            OP_RX2RY:
            begin
                mul_a = MUL_BITS'(rx2_s);
                mul_b = MUL_BITS'(ry_s);
            end
            OP_UPD_M1:
            begin
                if (r2_reg)
                begin
                    mul_a = MUL_BITS'(rx2_s);
                    mul_b = MUL_BITS'(two_y_m1);
                end
                else
                begin
                    mul_a = MUL_BITS'(ry2_s);
                    mul_b = MUL_BITS'(tx);
                end
            end
            OP_UPD_M2:
            begin
                if (r2_reg)
                begin
                    mul_a = MUL_BITS'(ry2_s);
                    mul_b = MUL_BITS'(x_reg);
                end
                else
                begin
                    mul_a = MUL_BITS'(rx2_s);
                    mul_b = MUL_BITS'(y_reg);
                end
            end
            OP_CMP_M1:
            begin
                mul_a = MUL_BITS'(ry2_s);
                mul_b = MUL_BITS'(x_reg);
            end
            OP_CMP_M2:
            begin
                mul_a = MUL_BITS'(rx2_s);
                mul_b = MUL_BITS'(y_reg);
            end
            OP_SW_TX:
            begin
                mul_a = MUL_BITS'(tx);
                mul_b = MUL_BITS'(tx);
            end
            OP_SW_RY2:
            begin
                mul_a = MUL_BITS'(ry2_s);
                mul_b = MUL_BITS'(prod_reg);
            end
            OP_SW_TY:
            begin
                mul_a = MUL_BITS'(ty);
                mul_b = MUL_BITS'(ty);
            end
            OP_SW_RX2:
            begin
                mul_a = MUL_BITS'(rx2_s);
                mul_b = MUL_BITS'(prod_reg);
            end
            OP_SW_RR:
            begin
                mul_a = MUL_BITS'(rx2_s);
                mul_b = MUL_BITS'(ry2_s);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    always_comb
    begin
        act_next  = act_reg;
        r2_next   = r2_reg;
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        rxh_next  = rxh_reg;
        ryh_next  = ryh_reg;
        rx2_next  = rx2_reg;
        ry2_next  = ry2_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        ox_next   = ox_reg;
        oy_next   = oy_reg;
        diag_next = diag_reg;
        d_next    = d_reg;
        tmp_next  = tmp_reg;
        prod_next = DEC_BITS'(mul_full);
        case (op)
            OP_LOAD:
            begin
                cx_next  = center_x;
                cy_next  = center_y;
                rxh_next = radius_x;
                ryh_next = radius_y;
                x_next   = COORD_BITS'(start_x);
                y_next   = COORD_BITS'(start_y);
                r2_next  = 1'b0;
                act_next = 1'b1;
            end
            OP_SQ_RY:
            begin
                rx2_next = SQ_BITS'(prod_reg);
            end
            OP_RX2RY:
            begin
                ry2_next = SQ_BITS'(prod_reg);
            end
            OP_INIT_D:
            begin
                d_next = ry2_4 + rx2_d - prod4;
            end
            OP_ADV:
            begin
                ox_next   = x_reg;
                oy_next   = y_reg;
                diag_next = diag_now;
                if (r2_reg)
                begin
                    y_next = y_dec;
                    if (diag_now)
                    begin
                        x_next = x_inc;
                    end
                end
                else
                begin
                    x_next = x_inc;
                    if (diag_now)
                    begin
                        y_next = y_dec;
                    end
                end
            end
            OP_UPD_M2:
            begin
                d_next = r2_reg ? (d_reg - prod4) : (d_reg + prod4);
            end
            OP_UPD_A2:
            begin
                if (diag_reg)
                begin
                    d_next = r2_reg ? (d_reg + prod8) : (d_reg - prod8);
                end
            end
            OP_CMP_M2:
            begin
                tmp_next = prod_reg;
            end
            OP_SW_TY:
            begin
                tmp_next = prod_reg;
            end
            OP_SW_RR:
            begin
                tmp_next = tmp_reg + prod4;
            end
            OP_SW_FIN:
            begin
                d_next  = tmp_reg - prod4;
                r2_next = 1'b1;
            end
            OP_CHECK_END:
            begin
                if (r2_reg && y_reg[COORD_BITS-1])
                begin
                    act_next = 1'b0;
                end
            end
            default:
            begin
                d_next = d_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            r2_reg  <= 1'b0;
        end
        else
        begin
            act_reg <= act_next;
            r2_reg  <= r2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        rxh_reg  <= rxh_next;
        ryh_reg  <= ryh_next;
        rx2_reg  <= rx2_next;
        ry2_reg  <= ry2_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        diag_reg <= diag_next;
        d_reg    <= d_next;
        tmp_reg  <= tmp_next;
        prod_reg <= prod_next;
    end

    assign stat.active     = act_reg;
    assign stat.region_two = r2_reg;
    // ry^2*x below rx^2*y, region one still holds
    assign stat.below      = tmp_reg < prod_reg;
    assign hold_cx         = cx_reg;
    assign hold_cy         = cy_reg;
    assign point_x         = ox_reg;
    assign point_y         = oy_reg;

    // an ellipse only ends from region two
    a_end_in_region_two: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(act_reg) |-> r2_reg)
        else $error("walk finished outside region two");

endmodule

// ===== src/mer_ctrl.sv =====
`timescale 1ns / 1ps
// ellipse sequencer, one datapath op per cycle except when waiting or deciding
module mer_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               kind,
    output logic               s_tready,
    input  mer_pkg::mer_stat_t stat,
    input  logic               emit_free,
    output mer_pkg::mer_cmd_t  cmd
);
    import mer_pkg::*;

    typedef enum logic [18:0] {
        ST_IDLE      = 19'b1 << 0,
        ST_SQ_RX     = 19'b1 << 1,
        ST_SQ_RY     = 19'b1 << 2,
        ST_RX2RY     = 19'b1 << 3,
        ST_INIT_D    = 19'b1 << 4,
        ST_UPD_M1    = 19'b1 << 5,
        ST_UPD_M2    = 19'b1 << 6,
        ST_UPD_A2    = 19'b1 << 7,
        ST_CMP_M1    = 19'b1 << 8,
        ST_CMP_M2    = 19'b1 << 9,
        ST_CMP_DEC   = 19'b1 << 10,
        ST_SW_TX     = 19'b1 << 11,
        ST_SW_RY2    = 19'b1 << 12,
        ST_SW_TY     = 19'b1 << 13,
        ST_SW_RX2    = 19'b1 << 14,
        ST_SW_RR     = 19'b1 << 15,
        ST_SW_FIN    = 19'b1 << 16,
        ST_CHECK_END = 19'b1 << 17,
        ST_EMIT      = 19'b1 << 18
    } mer_state_t;

    mer_state_t state_reg, state_next;
    logic       step_reg, step_next;

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        cmd.op        = OP_NONE;
        cmd.emit_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (kind == CMD_START)
                    begin
                        cmd.op     = OP_LOAD;
                        step_next  = 1'b0;
                        state_next = ST_SQ_RX;
                    end
                    else if (stat.active)
                    begin
                        cmd.op     = OP_ADV;
                        step_next  = 1'b1;
                        state_next = ST_UPD_M1;
                    end
                end
            end
            ST_SQ_RX:
            begin
                cmd.op     = OP_SQ_RX;
                state_next = ST_SQ_RY;
            end
            ST_SQ_RY:
            begin
                cmd.op     = OP_SQ_RY;
                state_next = ST_RX2RY;
            end
            ST_RX2RY:
            begin
                cmd.op     = OP_RX2RY;
                state_next = ST_INIT_D;
            end
            ST_INIT_D:
            begin
                cmd.op     = OP_INIT_D;
                state_next = ST_CMP_M1;
            end
            ST_UPD_M1:
            begin
                cmd.op     = OP_UPD_M1;
                state_next = ST_UPD_M2;
            end
            ST_UPD_M2:
            begin
                cmd.op     = OP_UPD_M2;
                state_next = ST_UPD_A2;
            end
            ST_UPD_A2:
            begin
                cmd.op     = OP_UPD_A2;
                state_next = stat.region_two ? ST_CHECK_END : ST_CMP_M1;
            end
            ST_CMP_M1:
            begin
                cmd.op     = OP_CMP_M1;
                state_next = ST_CMP_M2;
            end
            ST_CMP_M2:
            begin
                cmd.op     = OP_CMP_M2;
                state_next = ST_CMP_DEC;
            end
            ST_CMP_DEC:
            begin
                state_next = stat.below ? ST_CHECK_END : ST_SW_TX;
            end
            ST_SW_TX:
            begin
                cmd.op     = OP_SW_TX;
                state_next = ST_SW_RY2;
            end
            ST_SW_RY2:
            begin
                cmd.op     = OP_SW_RY2;
                state_next = ST_SW_TY;
            end
            ST_SW_TY:
            begin
                cmd.op     = OP_SW_TY;
                state_next = ST_SW_RX2;
            end
            ST_SW_RX2:
            begin
                cmd.op     = OP_SW_RX2;
                state_next = ST_SW_RR;
            end
            ST_SW_RR:
            begin
                cmd.op     = OP_SW_RR;
                state_next = ST_SW_FIN;
            end
            ST_SW_FIN:
            begin
                cmd.op     = OP_SW_FIN;
                state_next = ST_CHECK_END;
            end
            ST_CHECK_END:
            begin
                cmd.op     = OP_CHECK_END;
                state_next = step_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (emit_free)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // only a step hands a point to the output stage
    a_load_only_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> step_reg)
        else $error("point handed over after a start transaction");

    // a handed over point frees the input side at once
    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |=> s_tready)
        else $error("input not ready after point handover");

endmodule

// ===== src/mer_emit.sv =====
`timescale 1ns / 1ps
// output stage, holds one walk point and sends its four mirrored pixels
module mer_emit #(
    parameter int COORD_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic                         fin,
    input  logic signed [COORD_BITS-1:0] hold_cx,
    input  logic signed [COORD_BITS-1:0] hold_cy,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    output logic                         free,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic signed [COORD_BITS:0]   pixel_x,
    output logic signed [COORD_BITS:0]   pixel_y,
    output logic                         last_of_point,
    output logic                         final_point
);
    localparam logic [1:0] PIX_LAST = 2'd3;

    logic                         busy_reg, busy_next;
    logic [1:0]                   idx_reg, idx_next;
    logic signed [COORD_BITS-1:0] cx_reg, cx_next;
    logic signed [COORD_BITS-1:0] cy_reg, cy_next;
    logic signed [COORD_BITS-1:0] ox_reg, ox_next;
    logic signed [COORD_BITS-1:0] oy_reg, oy_next;
    logic                         fin_reg, fin_next;
    logic signed [COORD_BITS:0]   cx_e, cy_e, ox_e, oy_e;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        ox_next   = ox_reg;
        oy_next   = oy_reg;
        fin_next  = fin_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            cx_next   = hold_cx;
            cy_next   = hold_cy;
            ox_next   = point_x;
            oy_next   = point_y;
            fin_next  = fin;
        end
        else if (busy_reg && m_tready)
        begin
            idx_next = idx_reg + 2'd1;
            if (idx_reg == PIX_LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg  <= cx_next;
        cy_reg  <= cy_next;
        ox_reg  <= ox_next;
        oy_reg  <= oy_next;
        fin_reg <= fin_next;
    end

    assign cx_e = {cx_reg[COORD_BITS-1], cx_reg};
    assign cy_e = {cy_reg[COORD_BITS-1], cy_reg};
    assign ox_e = {ox_reg[COORD_BITS-1], ox_reg};
    assign oy_e = {oy_reg[COORD_BITS-1], oy_reg};

    // order (+x,+y) (-x,+y) (+x,-y) (-x,-y)
    assign pixel_x       = idx_reg[0] ? (cx_e - ox_e) : (cx_e + ox_e);
    assign pixel_y       = idx_reg[1] ? (cy_e - oy_e) : (cy_e + oy_e);
    assign last_of_point = (idx_reg == PIX_LAST);
    assign final_point   = fin_reg;
    assign m_tvalid      = busy_reg;
    assign free          = !busy_reg;

    a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !busy_reg)
        else $error("point loaded over one still being sent");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && last_of_point |=> !m_tvalid)
        else $error("output still valid after fourth pixel");

endmodule

// ===== src/midpoint_ellipse_rasterizer_top.sv =====
`timescale 1ns / 1ps
// top level of the midpoint ellipse rasterizer
// A start transaction (tuser low) loads the centre, both radii and the starting walk point,
// squares the radii and sets up the region-one decision value; it gives no output. Each step
// transaction (tuser high) sends the four mirrored pixels of the current walk point, in the
// order (+x,+y) (-x,+y) (+x,-y) (-x,-y), with tlast on the fourth and tuser high on all four
// of the last point of the ellipse, and then moves the walk on. A step while no ellipse is
// open is taken and dropped. All work goes through one shared multiplier, stepped by the
// sequencer, so the input side is busy while a start or step is worked on, through the extra
// region-two setup on the start or step where the walk crosses into region two, and while
// waiting for the output stage to take the point. The output stage holds one point and sends
// its four pixels at one per cycle, as the output side takes them, while the next transaction
// is being worked on. Decision values are kept as four times the real value in 48 bits,
// which makes the quarter and half terms exact.
module midpoint_ellipse_rasterizer_top #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10,
    localparam int IN_W  = ((2 * COORD_BITS + 2 * RADIUS_BITS + 2 * mer_pkg::START_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * (COORD_BITS + 1) + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    // input transactions
    input  logic             s_tvalid,
    output logic             s_tready,
    // center_x, center_y, radius_x, radius_y, start_x, start_y
    input  logic [IN_W-1:0]  s_tdata,
    // cmd: low starts an ellipse, high steps one point
    input  logic             s_tuser,
    // pixel transactions
    output logic             m_tvalid,
    input  logic             m_tready,
    // pixel_x, pixel_y
    output logic [OUT_W-1:0] m_tdata,
    // last_of_point
    output logic             m_tlast,
    // final_point
    output logic             m_tuser
);
    import mer_pkg::*;

    // field positions in s_tdata
    localparam int CX_LO = 0;
    localparam int CY_LO = COORD_BITS;
    localparam int RX_LO = 2 * COORD_BITS;
    localparam int RY_LO = RX_LO + RADIUS_BITS;
    localparam int SX_LO = RY_LO + RADIUS_BITS;
    localparam int SY_LO = SX_LO + START_BITS;

    logic signed [COORD_BITS-1:0]  center_x, center_y;
    logic        [RADIUS_BITS-1:0] radius_x, radius_y;
    logic        [START_BITS-1:0]  start_x, start_y;

    mer_cmd_t  cmd;
    mer_stat_t stat;
    logic      emit_free;

    logic signed [COORD_BITS-1:0] hold_cx, hold_cy, point_x, point_y;
    logic signed [COORD_BITS:0]   pixel_x, pixel_y;

    assign center_x = s_tdata[CX_LO +: COORD_BITS];
    assign center_y = s_tdata[CY_LO +: COORD_BITS];
    assign radius_x = s_tdata[RX_LO +: RADIUS_BITS];
    assign radius_y = s_tdata[RY_LO +: RADIUS_BITS];
    assign start_x  = s_tdata[SX_LO +: START_BITS];
    assign start_y  = s_tdata[SY_LO +: START_BITS];

    // sequencer, one datapath operation per cycle except while waiting or deciding the region
    mer_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .kind      (s_tuser),
        .s_tready  (s_tready),
        .stat      (stat),
        .emit_free (emit_free),
        .cmd       (cmd)
    );

    // walk state, decision value and the shared multiplier
    mer_datapath #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (cmd.op),
        .center_x (center_x),
        .center_y (center_y),
        .radius_x (radius_x),
        .radius_y (radius_y),
        .start_x  (start_x),
        .start_y  (start_y),
        .stat     (stat),
        .hold_cx  (hold_cx),
        .hold_cy  (hold_cy),
        .point_x  (point_x),
        .point_y  (point_y)
    );

    // output stage, the point is final once the walk has closed
    mer_emit #(
        .COORD_BITS (COORD_BITS)
    ) u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (cmd.emit_load),
        .fin           (!stat.active),
        .hold_cx       (hold_cx),
        .hold_cy       (hold_cy),
        .point_x       (point_x),
        .point_y       (point_y),
        .free          (emit_free),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .last_of_point (m_tlast),
        .final_point   (m_tuser)
    );

    // pixel_x in the low bits, zero fill above pixel_y
    assign m_tdata = OUT_W'({pixel_y, pixel_x});

endmodule
